@@ rtl/core/bezier_subdivision_defines.svh @@
// Assertion macros shared by the Bezier subdivision RTL.
`ifndef BEZIER_SUBDIVISION_DEFINES_SVH
`define BEZIER_SUBDIVISION_DEFINES_SVH

// Same-cycle implication, checked on every clock outside reset.
`define BZS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define BZS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bzs_pkg.sv @@
// Shared constants and types of the Bezier subdivision block.
`default_nettype none

package bzs_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_LEVELS = 8;
  localparam int COORD_W    = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int LEAF_W     = MAX_LEVELS + 1;
  localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
  localparam int CFG_W      = 4;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_W-1:0] CFG_LEVELS_RESET = 4'd5;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEAF   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_POINT   = 2'd0,
    ST_FEW     = 2'd1,
    ST_NO_LEAF = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    point_t  pt;
    logic    last;
    logic    fin;
    status_t status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/bezier_subdivision.sv @@
// Top level of the Bezier subdivision block: config register and result register.
//
//   Channel   Dir  Handshake              Carries
//   in_       in   in_valid / in_ready    in_kind, in_point_x, in_point_y
//   out_      out  out_valid / out_ready  out_x, out_y, out_last_of_leaf,
//                                         out_final_leaf, out_status
//   cfg_      in   cfg_valid / cfg_ready  cfg_subdivision_levels
//
// Append and clear requests leave the sequencer idle; an error request holds it until its result is taken.
// A leaf request with n points and L levels copies the points, runs L*(n-1) de Casteljau
// rounds and emits n points through the work buffer memory's single read and write port.
// Reset is synchronous; no clearing pass is needed, stores fill on demand.
// A stalled output holds in the result register; new inputs wait for the sequencer.
`default_nettype none
`include "bezier_subdivision_defines.svh"

module bezier_subdivision (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bzs_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bzs_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bzs_pkg::COORD_W-1:0] in_point_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bzs_pkg::COORD_W-1:0] out_x,
  output logic signed [bzs_pkg::COORD_W-1:0] out_y,
  output logic                               out_last_of_leaf,
  output logic                               out_final_leaf,
  output logic [bzs_pkg::STATUS_W-1:0]       out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bzs_pkg::CFG_W-1:0]          cfg_subdivision_levels
);
  import bzs_pkg::*;

  logic [CFG_W-1:0] levels_r;
  logic [LVL_W-1:0] levels_eff;
  logic             out_valid_r;
  res_t             out_res_r;
  logic             res_valid, res_take;
  res_t             res;

  // Config register, clamped to the deepest supported split
  assign cfg_ready  = 1'b1;
  assign levels_eff = (int'(levels_r) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : LVL_W'(levels_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= CFG_LEVELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      levels_r <= cfg_subdivision_levels;
    end
  end

  bzs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_kind    (in_kind),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .levels_eff (levels_eff),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // Result register: load when empty or when the held transfer completes
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_res_r.pt.x;
  assign out_y            = out_res_r.pt.y;
  assign out_last_of_leaf = out_res_r.last;
  assign out_final_leaf   = out_res_r.fin;
  assign out_status       = out_res_r.status;

  // Error results carry no point and close the leaf
  `BZS_ASSERT_IMP(a_err_shape, out_valid && (out_status != ST_POINT), out_last_of_leaf && !out_final_leaf && (out_x == '0) && (out_y == '0), "error result has point data")

  // The sequencer never offers a result while taking a request
  `BZS_ASSERT_IMP(a_res_busy, res_valid, !in_ready, "result offered while idle")

  // A leaf request always leaves the sequencer busy in the cycle after it is accepted
  `BZS_ASSERT_NXT(a_leaf_busy, in_valid && in_ready && (in_kind == KIND_LEAF), !in_ready, "leaf request did not start")

endmodule

`default_nettype wire

@@ rtl/core/bzs_midpoint.sv @@
// Floor midpoint of two Q16.16 points, exact 33-bit sums.
`default_nettype none

module bzs_midpoint (
  input  bzs_pkg::point_t a,
  input  bzs_pkg::point_t b,
  output bzs_pkg::point_t m
);
  import bzs_pkg::*;

  logic signed [COORD_W:0] sum_x;
  logic signed [COORD_W:0] sum_y;

  // Sign-extend, add, then drop the low bit (arithmetic floor of half)
  assign sum_x = {a.x[COORD_W-1], a.x} + {b.x[COORD_W-1], b.x};
  assign sum_y = {a.y[COORD_W-1], a.y} + {b.y[COORD_W-1], b.y};
  assign m.x   = sum_x[COORD_W:1];
  assign m.y   = sum_y[COORD_W:1];

endmodule

`default_nettype wire

@@ rtl/core/bzs_engine.sv @@
// Control store, work buffer and the in-place de Casteljau sequencer.
`default_nettype none

module bzs_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bzs_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [bzs_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bzs_pkg::COORD_W-1:0] in_point_y,
  input  logic [bzs_pkg::LVL_W-1:0]     levels_eff,
  output logic                          res_valid,
  output bzs_pkg::res_t                 res,
  input  logic                          res_take
);
  import bzs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ERR     = 6'b000010,
    S_COPY    = 6'b000100,
    S_SWEEP   = 6'b001000,
    S_EMIT_RD = 6'b010000,
    S_EMIT_LD = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEAF_W-1:0]   leaf_r, leaf_nxt;
  logic [LEAF_W-1:0]   path_r, path_nxt;
  logic [LVL_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    c_r, c_nxt;
  logic [CNT_W-1:0]    rnd_r, rnd_nxt;
  logic [IDX_W-1:0]    i_r, i_nxt;
  logic                fin_r, fin_nxt;
  status_t             err_r, err_nxt;

  point_t              store_mem [MAX_POINTS];
  point_t              work_mem  [MAX_POINTS];
  point_t              store_rd_r, work_rd_r, prev_r;

  logic                store_we, work_we;
  logic [IDX_W-1:0]    store_waddr, store_raddr, work_waddr, work_raddr;
  point_t              store_wdata, work_wdata, mid_pt;

  logic                accept, asc, is_last_pt;
  logic [CNT_W-1:0]    len, n_m1;
  logic [LEAF_W-1:0]   leaves;
  logic [LVL_W:0]      shamt;
  logic [CNT_W-1:0]    sw_raddr, sw_waddr;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign n_m1       = cnt_r - CNT_W'(1);
  assign len        = cnt_r - rnd_r;
  assign leaves     = LEAF_W'(1) << levels_eff;
  assign shamt      = (LVL_W + 1)'(LEAF_W) - {1'b0, levels_eff};
  assign is_last_pt = (CNT_W'(i_r) == n_m1);

  // Right half sweeps upward, left half downward; both leave the result in place
  assign asc      = path_r[LEAF_W-1];
  assign sw_raddr = asc ? c_r : (n_m1 - c_r);
  assign sw_waddr = asc ? (c_r - CNT_W'(2)) : (cnt_r + CNT_W'(1) - c_r);

  bzs_midpoint u_mid (
    .a (prev_r),
    .b (work_rd_r),
    .m (mid_pt)
  );

  // Control store port selection
  assign store_we    = accept && (in_kind == KIND_APPEND) && (cnt_r < CNT_W'(MAX_POINTS));
  assign store_waddr = cnt_r[IDX_W-1:0];
  assign store_wdata = '{x: in_point_x, y: in_point_y};
  assign store_raddr = c_r[IDX_W-1:0];

  // Work buffer port selection
  always_comb begin
    work_we    = 1'b0;
    work_waddr = sw_waddr[IDX_W-1:0];
    work_wdata = mid_pt;
    work_raddr = i_r;
    if (state_r == S_COPY) begin
      work_we    = (c_r != '0);
      work_waddr = IDX_W'(c_r - CNT_W'(1));
      work_wdata = store_rd_r;
    end else if (state_r == S_SWEEP) begin
      work_we    = (c_r >= CNT_W'(2));
      work_raddr = sw_raddr[IDX_W-1:0];
    end
  end

  // Memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rd_r <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_r <= work_mem[work_raddr];
    prev_r    <= work_rd_r;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    leaf_nxt  = leaf_r;
    path_nxt  = path_r;
    rem_nxt   = rem_r;
    c_nxt     = c_r;
    rnd_nxt   = rnd_r;
    i_nxt     = i_r;
    fin_nxt   = fin_r;
    err_nxt   = err_r;
    res_valid = 1'b0;
    res       = '{pt: '0, last: 1'b1, fin: 1'b0, status: err_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_APPEND: begin
              if (cnt_r >= CNT_W'(MAX_POINTS)) begin
                err_nxt   = ST_FULL;
                state_nxt = S_ERR;
              end else begin
                cnt_nxt  = cnt_r + CNT_W'(1);
                leaf_nxt = '0;
              end
            end
            KIND_CLEAR: begin
              cnt_nxt  = '0;
              leaf_nxt = '0;
            end
            KIND_LEAF: begin
              if (cnt_r < CNT_W'(2)) begin
                err_nxt   = ST_FEW;
                state_nxt = S_ERR;
              end else if (leaf_r >= leaves) begin
                err_nxt   = ST_NO_LEAF;
                state_nxt = S_ERR;
              end else begin
                fin_nxt   = (leaf_r == leaves - LEAF_W'(1));
                path_nxt  = leaf_r << shamt;
                rem_nxt   = levels_eff;
                leaf_nxt  = leaf_r + LEAF_W'(1);
                c_nxt     = '0;
                state_nxt = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end

      S_ERR: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      // Stream the control points into the work buffer
      S_COPY: begin
        c_nxt = c_r + CNT_W'(1);
        if (c_r == cnt_r) begin
          c_nxt   = '0;
          rnd_nxt = CNT_W'(1);
          i_nxt   = '0;
          if (rem_r == '0) begin
            state_nxt = S_EMIT_RD;
          end else begin
            state_nxt = S_SWEEP;
          end
        end
      end

      // One de Casteljau round per pass; n-1 rounds per level
      S_SWEEP: begin
        c_nxt = c_r + CNT_W'(1);
        if (c_r == len + CNT_W'(1)) begin
          c_nxt = '0;
          if (rnd_r == n_m1) begin
            rnd_nxt  = CNT_W'(1);
            rem_nxt  = rem_r - LVL_W'(1);
            path_nxt = path_r << 1;
            if (rem_r == LVL_W'(1)) begin
              i_nxt     = '0;
              state_nxt = S_EMIT_RD;
            end
          end else begin
            rnd_nxt = rnd_r + CNT_W'(1);
          end
        end
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        res_valid = 1'b1;
        res       = '{pt: work_rd_r, last: is_last_pt, fin: fin_r, status: ST_POINT};
        if (res_take) begin
          if (is_last_pt) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      leaf_r  <= '0;
      path_r  <= '0;
      rem_r   <= '0;
      c_r     <= '0;
      rnd_r   <= '0;
      i_r     <= '0;
      fin_r   <= 1'b0;
      err_r   <= ST_POINT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      leaf_r  <= leaf_nxt;
      path_r  <= path_nxt;
      rem_r   <= rem_nxt;
      c_r     <= c_nxt;
      rnd_r   <= rnd_nxt;
      i_r     <= i_nxt;
      fin_r   <= fin_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire
